// File: sv/nns_pkg.sv
package nns_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int COORD_BITS_DEF = 16;

    localparam int IN_COORD_W = 16;
    localparam int OP_W       = 2;
    localparam int DIMS_W     = 2;
    localparam int OUT_IDX_W  = 10;
    localparam int DIST_W     = 34;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;
    localparam logic [DIMS_W-1:0] DIMS_TWO   = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]              operation;
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] nearest_index;
        logic [DIST_W-1:0]    squared_distance;
    } out_item_t;

    typedef struct packed {
        logic clear_store;
        logic load_node;
        logic start_scan;
        logic issue_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic store_empty;
        logic scan_last;
        logic pipe_busy;
    } status_t;

endpackage

// File: sv/nns_ram.sv
module nns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/nns_ctrl.sv
module nns_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [nns_pkg::OP_W-1:0]    s_op,
    output logic                        m_valid,
    input  logic                        m_ready,
    output nns_pkg::cmd_t               cmd,
    input  nns_pkg::status_t            status
);

    import nns_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        s_ready      = (state_reg == ST_IDLE);
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        OP_CLEAR: cmd.clear_store = 1'b1;
                        OP_LOAD:  cmd.load_node = 1'b1;
                        OP_QUERY: begin
                            cmd.start_scan = 1'b1;
                            state_next = status.store_empty ? ST_FINISH : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.issue_read = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!status.pipe_busy && (!m_valid_reg || m_ready)) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/nns_dpath.sv
module nns_dpath #(
    parameter int MAX_NODES  = nns_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = nns_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nns_pkg::DIMS_W-1:0]   cfg_wr_data,
    input  nns_pkg::in_item_t            s_data,
    input  nns_pkg::cmd_t                cmd,
    output nns_pkg::status_t             status,
    output nns_pkg::out_item_t           m_data
);

    import nns_pkg::*;

    // coordinates never exceed the 16-bit input fields
    localparam int CW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int SQ_W  = 2 * (CW + 1);
    localparam int DW    = SQ_W + 2;
    localparam int EXT_W = (DW > DIST_W) ? DW : DIST_W;
    localparam int RAM_W = 3 * CW;

    logic [DIMS_W-1:0] dims_reg;
    logic [CNT_W-1:0]  node_count_reg;
    logic [IDX_W-1:0]  scan_addr_reg;
    logic              store_full;

    logic signed [CW-1:0] qx_reg, qy_reg, qz_reg;

    logic [RAM_W-1:0] rd_data;
    logic             ram_wr_en;

    logic             rv_reg;
    logic [IDX_W-1:0] rv_idx_reg;

    logic signed [CW-1:0] nx, ny, nz;
    logic signed [CW:0]   dx, dy, dz;
    logic signed [SQ_W-1:0] sqx_next, sqy_next, sqz_next;

    logic             sq_valid_reg;
    logic [IDX_W-1:0] sq_idx_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;

    logic             dist_valid_reg;
    logic [IDX_W-1:0] dist_idx_reg;
    logic [DW-1:0]    dist_reg, dist_next;

    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [DW-1:0]    best_reg;

    logic [EXT_W-1:0] best_ext;
    logic [31:0]      best_idx_ext;
    out_item_t        m_data_reg, m_data_next;

    assign store_full = (node_count_reg == CNT_W'(MAX_NODES));
    assign ram_wr_en  = cmd.load_node && !store_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg       <= DIMS_RESET;
            node_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                dims_reg <= cfg_wr_data;
            end
            if (cmd.clear_store) begin
                node_count_reg <= '0;
            end else if (ram_wr_en) begin
                node_count_reg <= node_count_reg + CNT_W'(1);
            end
        end
    end

    nns_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_NODES)
    ) u_node_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(node_count_reg[IDX_W-1:0]),
        .wr_data({s_data.coord_x[CW-1:0], s_data.coord_y[CW-1:0], s_data.coord_z[CW-1:0]}),
        .rd_en  (cmd.issue_read),
        .rd_addr(scan_addr_reg),
        .rd_data(rd_data)
    );

    // query point and scan address
    always_ff @(posedge aclk) begin
        if (cmd.start_scan) begin
            qx_reg        <= s_data.coord_x[CW-1:0];
            qy_reg        <= s_data.coord_y[CW-1:0];
            qz_reg        <= s_data.coord_z[CW-1:0];
            scan_addr_reg <= '0;
        end else if (cmd.issue_read) begin
            scan_addr_reg <= scan_addr_reg + IDX_W'(1);
        end
    end

    // squares of the axis differences
    assign nx = rd_data[3*CW-1:2*CW];
    assign ny = rd_data[2*CW-1:CW];
    assign nz = rd_data[CW-1:0];
    assign dx = (CW + 1)'(nx) - (CW + 1)'(qx_reg);
    assign dy = (CW + 1)'(ny) - (CW + 1)'(qy_reg);
    assign dz = (CW + 1)'(nz) - (CW + 1)'(qz_reg);
    assign sqx_next = dx * dx;
    assign sqy_next = dy * dy;
    assign sqz_next = dz * dz;

    always_comb begin
        dist_next = DW'(sqx_reg);
        if (dims_reg >= DIMS_TWO) begin
            dist_next = dist_next + DW'(sqy_reg);
        end
        if (dims_reg >= DIMS_THREE) begin
            dist_next = dist_next + DW'(sqz_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg         <= 1'b0;
            sq_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end else begin
            rv_reg         <= cmd.issue_read;
            sq_valid_reg   <= rv_reg;
            dist_valid_reg <= sq_valid_reg;
            if (cmd.start_scan) begin
                best_valid_reg <= 1'b0;
            end else if (dist_valid_reg) begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rv_idx_reg   <= scan_addr_reg;
        sq_idx_reg   <= rv_idx_reg;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        sqz_reg      <= sqz_next;
        dist_idx_reg <= sq_idx_reg;
        dist_reg     <= dist_next;
        if (dist_valid_reg && (!best_valid_reg || dist_reg < best_reg)) begin
            best_reg     <= dist_reg;
            best_idx_reg <= dist_idx_reg;
        end
    end

    // result formatting
    assign best_ext     = EXT_W'(best_reg);
    assign best_idx_ext = 32'(best_idx_reg);

    always_comb begin
        m_data_next.found = best_valid_reg;
        if (best_valid_reg) begin
            m_data_next.nearest_index = best_idx_ext[OUT_IDX_W-1:0];
            if (best_ext > EXT_W'(DIST_MAX)) begin
                m_data_next.squared_distance = DIST_MAX;
            end else begin
                m_data_next.squared_distance = best_ext[DIST_W-1:0];
            end
        end else begin
            m_data_next.nearest_index    = '0;
            m_data_next.squared_distance = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

    assign status.store_empty = (node_count_reg == '0);
    assign status.scan_last   = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == node_count_reg);
    assign status.pipe_busy   = rv_reg || sq_valid_reg || dist_valid_reg;

endmodule

// File: sv/nearest_node_search.sv
// Nearest node search: brute-force nearest neighbor, squared Euclidean distance.
// Input channel (s_valid/s_ready/s_data) carries three kinds of transaction:
//   clear empties the node store, load appends one node (dropped when full),
//   query scans all stored nodes and yields one result transaction.
// Result channel (m_valid/m_ready/m_data) carries found, nearest_index and
//   squared_distance; ties go to the lowest index.
// cfg_wr_en/cfg_wr_data write the dimensions register (1..3 axes, 0 acts as 1).
// Clear and load are carried out as soon as they are accepted. A query scans
//   one node a cycle from the single read port of the node RAM through the
//   RAM read, square, sum and compare stages; an empty store skips the scan
//   and goes straight to the result. The next transaction is taken once the
//   result is in the output register.
// A finished result waits in the output register while m_ready is low; clears
//   and loads keep being accepted meanwhile, and a new query scans but holds
//   its result until the register drains.
// Reset (aresetn low, synchronous) empties the store, sets dimensions to 3 and
//   drops any pending result.
module nearest_node_search #(
    parameter int MAX_NODES  = nns_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = nns_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [nns_pkg::DIMS_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  nns_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output nns_pkg::out_item_t          m_data
);

    import nns_pkg::*;

    cmd_t    cmd;
    status_t status;

    nns_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op   (s_data.operation),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    nns_dpath #(
        .MAX_NODES (MAX_NODES),
        .COORD_BITS(COORD_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_data     (s_data),
        .cmd        (cmd),
        .status     (status),
        .m_data     (m_data)
    );

endmodule
